@@ rtl/cer_pkg.sv @@
package cer_pkg;

    // Design limits and angle format
    localparam int MAX_FACE_SIZE = 4096;
    localparam int FRAC_BITS     = 16;

    // Angle divider: quotient bits and remainder width
    localparam int ANG_Q_W   = FRAC_BITS + 1;
    localparam int ANG_REM_W = 31;

    // Face coordinate divider: quotient bits, remainder and divisor widths
    localparam int CRD_Q_W   = 13;
    localparam int CRD_REM_W = 45;
    localparam int CRD_DIV_W = 32;

    localparam logic [15:0] QUARTER_TURN = 16'(1 << (FRAC_BITS - 2));

    typedef enum logic [2:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } face_t;

    typedef struct packed {
        logic [12:0] out_col;
        logic [11:0] out_row;
    } remap_in_t;

    typedef struct packed {
        face_t       face;
        logic [11:0] face_col;
        logic [11:0] face_row;
    } remap_out_t;

    // Face size after saturation and the two divisors derived from it
    typedef struct packed {
        logic [12:0] n;
        logic [12:0] two_n_m1;
        logic [11:0] n_m1;
    } geom_t;

    // Classified direction: face, major magnitude, column and row numerators
    typedef struct packed {
        face_t              face;
        logic [30:0]        m;
        logic signed [32:0] cn;
        logic signed [32:0] rn;
    } cls_t;

    // Quarter-wave sine table, Q1.15
    function automatic logic [14:0] qsin(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd3212;
            5'd2:    v = 15'd6393;
            5'd3:    v = 15'd9512;
            5'd4:    v = 15'd12540;
            5'd5:    v = 15'd15447;
            5'd6:    v = 15'd18205;
            5'd7:    v = 15'd20788;
            5'd8:    v = 15'd23170;
            5'd9:    v = 15'd25330;
            5'd10:   v = 15'd27246;
            5'd11:   v = 15'd28899;
            5'd12:   v = 15'd30274;
            5'd13:   v = 15'd31357;
            5'd14:   v = 15'd32138;
            5'd15:   v = 15'd32610;
            5'd16:   v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Sine of an angle in turns, table lookup plus truncated interpolation
    function automatic logic signed [15:0] sine_q15(input logic [15:0] ang);
        logic [1:0]  q;
        logic [14:0] u;
        logic [4:0]  idx;
        logic [9:0]  r;
        logic [14:0] v0;
        logic [14:0] v1;
        logic [12:0] dlt;
        logic [22:0] prod;
        logic [15:0] v;
        q   = ang[15:14];
        u   = {1'b0, ang[13:0]};
        if (q[0])
            u = 15'(QUARTER_TURN) - u;
        idx = u[14:10];
        r   = u[9:0];
        v0  = qsin(idx);
        v   = {1'b0, v0};
        v1  = 15'd0;
        dlt = 13'd0;
        prod = 23'd0;
        if (idx < 5'd16)
        begin
            v1   = qsin(5'(idx + 5'd1));
            dlt  = 13'(v1 - v0);
            prod = 23'(dlt) * 23'(r);
            v    = v + 16'(prod >> 10);
        end
        return q[1] ? $signed(16'(-v)) : $signed(v);
    endfunction

endpackage

@@ rtl/cer_front.sv @@
module cer_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  cer_pkg::remap_in_t req,
    input  cer_pkg::geom_t geom,
    output logic           cls_valid,
    output cer_pkg::cls_t  cls
);

    localparam int QW = cer_pkg::ANG_Q_W;
    localparam int RW = cer_pkg::ANG_REM_W;

    // Input stage
    logic        v0_reg;
    logic [12:0] col_reg;
    logic [11:0] row_reg;

    // Angle dividers, one quotient bit per stage
    logic          dv_reg   [1:QW];
    logic [RW-1:0] azr_reg  [1:QW];
    logic [QW-1:0] azq_reg  [1:QW];
    logic [RW-1:0] por_reg  [1:QW];
    logic [QW-1:0] poq_reg  [1:QW];
    logic [RW-1:0] azr_cur  [0:QW];
    logic [QW-1:0] azq_cur  [0:QW];
    logic [RW-1:0] por_cur  [0:QW];
    logic [QW-1:0] poq_cur  [0:QW];
    logic [RW-1:0] azr_next [1:QW];
    logic [QW-1:0] azq_next [1:QW];
    logic [RW-1:0] por_next [1:QW];
    logic [QW-1:0] poq_next [1:QW];
    logic [RW-1:0] az_dsh;
    logic [RW-1:0] po_dsh;

    // Trig, product, magnitude and classify stages
    logic               vt_reg;
    logic signed [15:0] st_reg;
    logic signed [15:0] ct_reg;
    logic signed [15:0] sp_reg;
    logic signed [15:0] cp_reg;
    logic               vp_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] z_reg;
    logic               vm_reg;
    logic signed [31:0] xm_reg;
    logic signed [31:0] ym_reg;
    logic signed [31:0] zm_reg;
    logic [30:0]        ax_reg;
    logic [30:0]        ay_reg;
    logic [30:0]        azm_reg;
    logic               vc_reg;
    cer_pkg::cls_t      cls_reg;
    cer_pkg::cls_t      cls_next;
    logic [15:0]        az_ang;
    logic [15:0]        po_ang;
    logic signed [32:0] mi;
    logic signed [32:0] xe;
    logic signed [32:0] ye;
    logic signed [32:0] ze;

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 1; i <= QW; i++)
                dv_reg[i] <= 1'b0;
            vt_reg <= 1'b0;
            vp_reg <= 1'b0;
            vm_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            v0_reg    <= accept;
            dv_reg[1] <= v0_reg;
            for (int i = 2; i <= QW; i++)
                dv_reg[i] <= dv_reg[i-1];
            vt_reg <= dv_reg[QW];
            vp_reg <= vt_reg;
            vm_reg <= vp_reg;
            vc_reg <= vm_reg;
        end
    end

    // Capture and saturate the pixel position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= (req.out_col > geom.two_n_m1) ? geom.two_n_m1 : req.out_col;
            row_reg <= (req.out_row > geom.n_m1) ? geom.n_m1 : req.out_row;
        end
    end

    // Restoring division: az = col*2^F/(2N-1), pol = row*2^(F-1)/(N-1)
    always_comb
    begin
        azr_cur[0] = RW'(col_reg) << cer_pkg::FRAC_BITS;
        por_cur[0] = RW'(row_reg) << (cer_pkg::FRAC_BITS - 1);
        azq_cur[0] = '0;
        poq_cur[0] = '0;
        for (int i = 1; i <= QW; i++)
        begin
            azr_cur[i] = azr_reg[i];
            azq_cur[i] = azq_reg[i];
            por_cur[i] = por_reg[i];
            poq_cur[i] = poq_reg[i];
        end
        az_dsh = '0;
        po_dsh = '0;
        for (int i = 1; i <= QW; i++)
        begin
            az_dsh = RW'(geom.two_n_m1) << (QW - i);
            po_dsh = RW'(geom.n_m1) << (QW - i);
            if (azr_cur[i-1] >= az_dsh)
            begin
                azr_next[i] = azr_cur[i-1] - az_dsh;
                azq_next[i] = azq_cur[i-1] | (QW'(1) << (QW - i));
            end
            else
            begin
                azr_next[i] = azr_cur[i-1];
                azq_next[i] = azq_cur[i-1];
            end
            if (por_cur[i-1] >= po_dsh)
            begin
                por_next[i] = por_cur[i-1] - po_dsh;
                poq_next[i] = poq_cur[i-1] | (QW'(1) << (QW - i));
            end
            else
            begin
                por_next[i] = por_cur[i-1];
                poq_next[i] = poq_cur[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= QW; i++)
        begin
            azr_reg[i] <= azr_next[i];
            azq_reg[i] <= azq_next[i];
            por_reg[i] <= por_next[i];
            poq_reg[i] <= poq_next[i];
        end
    end

    // Angles wrap at a full turn
    assign az_ang = azq_reg[QW][15:0];
    assign po_ang = poq_reg[QW][15:0];

    // Sine and cosine of both angles
    always_ff @(posedge clk)
    begin
        st_reg <= cer_pkg::sine_q15(az_ang);
        ct_reg <= cer_pkg::sine_q15(16'(az_ang + cer_pkg::QUARTER_TURN));
        sp_reg <= cer_pkg::sine_q15(po_ang);
        cp_reg <= cer_pkg::sine_q15(16'(po_ang + cer_pkg::QUARTER_TURN));
    end

    // Direction vector, Q2.30
    always_ff @(posedge clk)
    begin
        x_reg <= 32'(ct_reg) * 32'(sp_reg);
        y_reg <= 32'(st_reg) * 32'(sp_reg);
        z_reg <= 32'(cp_reg) <<< 15;
    end

    // Component magnitudes
    always_ff @(posedge clk)
    begin
        xm_reg  <= x_reg;
        ym_reg  <= y_reg;
        zm_reg  <= z_reg;
        ax_reg  <= x_reg[31] ? 31'(-x_reg) : x_reg[30:0];
        ay_reg  <= y_reg[31] ? 31'(-y_reg) : y_reg[30:0];
        azm_reg <= z_reg[31] ? 31'(-z_reg) : z_reg[30:0];
    end

    // Major axis, face and numerators; ties go to X, then Y
    always_comb
    begin
        xe = 33'(xm_reg);
        ye = 33'(ym_reg);
        ze = 33'(zm_reg);
        cls_next = '0;
        if (ax_reg >= ay_reg && ax_reg >= azm_reg)
        begin
            cls_next.m = ax_reg;
            mi = $signed({2'b00, ax_reg});
            cls_next.face = xm_reg[31] ? cer_pkg::FACE_NX : cer_pkg::FACE_PX;
            cls_next.cn   = xm_reg[31] ? 33'(mi - ye) : 33'(mi + ye);
            cls_next.rn   = 33'(mi - ze);
        end
        else if (ay_reg >= azm_reg)
        begin
            cls_next.m = ay_reg;
            mi = $signed({2'b00, ay_reg});
            cls_next.face = ym_reg[31] ? cer_pkg::FACE_PY : cer_pkg::FACE_NY;
            cls_next.cn   = ym_reg[31] ? 33'(mi + xe) : 33'(mi - xe);
            cls_next.rn   = 33'(mi - ze);
        end
        else
        begin
            cls_next.m = azm_reg;
            mi = $signed({2'b00, azm_reg});
            cls_next.face = zm_reg[31] ? cer_pkg::FACE_NZ : cer_pkg::FACE_PZ;
            cls_next.cn   = 33'(mi + ye);
            cls_next.rn   = zm_reg[31] ? 33'(mi - xe) : 33'(mi + xe);
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign cls_valid = vc_reg;
    assign cls       = cls_reg;

endmodule

@@ rtl/cer_queue.sv @@
module cer_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cer_pkg::cls_t push_data,
    output logic          pop_valid,
    output cer_pkg::cls_t pop_data,
    output logic          full
);

    // Two-entry queue; the back end drains it every cycle it holds data
    cer_pkg::cls_t mem [0:1];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          pop;

    assign pop       = (count_reg != 2'd0);
    assign pop_valid = pop;
    assign pop_data  = mem[rd_ptr_reg];
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + 2'(push) - 2'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

@@ rtl/cer_back.sv @@
module cer_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cer_pkg::cls_t      cls,
    input  cer_pkg::geom_t     geom,
    output logic               done,
    output cer_pkg::remap_out_t result
);

    localparam int QW = cer_pkg::CRD_Q_W;
    localparam int RW = cer_pkg::CRD_REM_W;
    localparam int DW = cer_pkg::CRD_DIV_W;

    // Numerator stage
    logic           v0_reg;
    cer_pkg::face_t face0_reg;
    logic           zc0_reg;
    logic           zr0_reg;
    logic [RW-1:0]  nc0_reg;
    logic [RW-1:0]  nr0_reg;
    logic [DW-1:0]  d0_reg;
    logic           zc;
    logic           zr;

    // Coordinate dividers, one quotient bit per stage
    logic           dv_reg   [1:QW];
    cer_pkg::face_t face_reg [1:QW];
    logic           zc_reg   [1:QW];
    logic           zr_reg   [1:QW];
    logic [DW-1:0]  d_reg    [1:QW];
    logic [RW-1:0]  cr_reg   [1:QW];
    logic [QW-1:0]  cq_reg   [1:QW];
    logic [RW-1:0]  rr_reg   [1:QW];
    logic [QW-1:0]  rq_reg   [1:QW];
    logic [RW-1:0]  cr_cur   [0:QW];
    logic [QW-1:0]  cq_cur   [0:QW];
    logic [RW-1:0]  rr_cur   [0:QW];
    logic [QW-1:0]  rq_cur   [0:QW];
    logic [RW-1:0]  cr_next  [1:QW];
    logic [QW-1:0]  cq_next  [1:QW];
    logic [RW-1:0]  rr_next  [1:QW];
    logic [QW-1:0]  rq_next  [1:QW];
    logic [DW-1:0]  d_cur    [0:QW];
    logic [RW-1:0]  dsh;

    // Output stage
    logic                done_reg;
    cer_pkg::remap_out_t result_reg;
    logic [QW-1:0]       cq_fin;
    logic [QW-1:0]       rq_fin;

    // Nonpositive numerator or zero major magnitude gives coordinate zero
    assign zc = (cls.m == 31'd0) || cls.cn[32] || (cls.cn == 33'sd0);
    assign zr = (cls.m == 31'd0) || cls.rn[32] || (cls.rn == 33'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int i = 1; i <= QW; i++)
                dv_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg    <= in_valid;
            dv_reg[1] <= v0_reg;
            for (int i = 2; i <= QW; i++)
                dv_reg[i] <= dv_reg[i-1];
            done_reg <= dv_reg[QW];
        end
    end

    // Scale numerators by N, divisor is 2m
    always_ff @(posedge clk)
    begin
        face0_reg <= cls.face;
        zc0_reg   <= zc;
        zr0_reg   <= zr;
        nc0_reg   <= zc ? '0 : RW'(cls.cn[31:0]) * RW'(geom.n);
        nr0_reg   <= zr ? '0 : RW'(cls.rn[31:0]) * RW'(geom.n);
        d0_reg    <= {cls.m, 1'b0};
    end

    // Restoring division, quotient bounded by N
    always_comb
    begin
        cr_cur[0] = nc0_reg;
        rr_cur[0] = nr0_reg;
        cq_cur[0] = '0;
        rq_cur[0] = '0;
        d_cur[0]  = d0_reg;
        for (int i = 1; i <= QW; i++)
        begin
            cr_cur[i] = cr_reg[i];
            cq_cur[i] = cq_reg[i];
            rr_cur[i] = rr_reg[i];
            rq_cur[i] = rq_reg[i];
            d_cur[i]  = d_reg[i];
        end
        dsh = '0;
        for (int i = 1; i <= QW; i++)
        begin
            dsh = RW'(d_cur[i-1]) << (QW - i);
            if (cr_cur[i-1] >= dsh)
            begin
                cr_next[i] = cr_cur[i-1] - dsh;
                cq_next[i] = cq_cur[i-1] | (QW'(1) << (QW - i));
            end
            else
            begin
                cr_next[i] = cr_cur[i-1];
                cq_next[i] = cq_cur[i-1];
            end
            if (rr_cur[i-1] >= dsh)
            begin
                rr_next[i] = rr_cur[i-1] - dsh;
                rq_next[i] = rq_cur[i-1] | (QW'(1) << (QW - i));
            end
            else
            begin
                rr_next[i] = rr_cur[i-1];
                rq_next[i] = rq_cur[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg[1] <= face0_reg;
        zc_reg[1]   <= zc0_reg;
        zr_reg[1]   <= zr0_reg;
        for (int i = 2; i <= QW; i++)
        begin
            face_reg[i] <= face_reg[i-1];
            zc_reg[i]   <= zc_reg[i-1];
            zr_reg[i]   <= zr_reg[i-1];
        end
        for (int i = 1; i <= QW; i++)
        begin
            d_reg[i]  <= d_cur[i-1];
            cr_reg[i] <= cr_next[i];
            cq_reg[i] <= cq_next[i];
            rr_reg[i] <= rr_next[i];
            rq_reg[i] <= rq_next[i];
        end
    end

    // Zero the flagged coordinates, clamp the rest to N-1
    always_comb
    begin
        cq_fin = cq_reg[QW];
        rq_fin = rq_reg[QW];
        if (zc_reg[QW])
            cq_fin = '0;
        else if (cq_fin > QW'(geom.n_m1))
            cq_fin = QW'(geom.n_m1);
        if (zr_reg[QW])
            rq_fin = '0;
        else if (rq_fin > QW'(geom.n_m1))
            rq_fin = QW'(geom.n_m1);
    end

    always_ff @(posedge clk)
    begin
        result_reg.face     <= face_reg[QW];
        result_reg.face_col <= cq_fin[11:0];
        result_reg.face_row <= rq_fin[11:0];
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_col_in_face: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.face_col <= geom.n_m1 && result.face_row <= geom.n_m1))
        else $error("face coordinate beyond face edge");

endmodule

@@ rtl/cubemap_equirect_pixel_remap_core.sv @@
// Cube-map to equirectangular pixel remapper.
// Command channel: present a panorama pixel (req.out_col, req.out_row) with
// start high; the transaction is taken at a rising edge where busy is low.
// Result channel: done is high for exactly one cycle with result (face,
// face_col, face_row) valid; the receiver must take it in that cycle.
// Config: cfg_we writes cfg_wdata into face_size (edge N of a cube face);
// write only while no transaction is in flight.
// Throughput: one transaction per clock, sustained. The front end (two
// 17-stage angle dividers, sine lookup, direction products, major-axis
// classification) feeds a two-entry queue; the back end (two 13-stage
// coordinate dividers and the clamp) drains it every cycle.
// Results leave in acceptance order. busy only rises if the queue fills,
// which the always-draining back end prevents, so start may be held high
// every cycle.
// Reset (rst_n low, asynchronous) empties every pipeline stage and the
// queue and sets face_size to 512.
module cubemap_equirect_pixel_remap_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cer_pkg::remap_in_t  req,
    output logic                done,
    output cer_pkg::remap_out_t result,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_wdata
);

    logic [12:0]    face_size_reg;
    cer_pkg::geom_t geom;
    logic           accept;
    logic           fr_valid;
    cer_pkg::cls_t  fr_cls;
    logic           q_valid;
    cer_pkg::cls_t  q_cls;
    logic           q_full;

    // Face size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            face_size_reg <= 13'd512;
        else if (cfg_we)
            face_size_reg <= cfg_wdata;
    end

    // Saturate N to 2..MAX_FACE_SIZE and derive the divisors
    always_comb
    begin
        if (face_size_reg < 13'd2)
            geom.n = 13'd2;
        else if (face_size_reg > 13'(cer_pkg::MAX_FACE_SIZE))
            geom.n = 13'(cer_pkg::MAX_FACE_SIZE);
        else
            geom.n = face_size_reg;
        geom.two_n_m1 = 13'({geom.n, 1'b0} - 14'd1);
        geom.n_m1     = 12'(geom.n - 13'd1);
    end

    assign accept = start && !busy;
    assign busy   = q_full;

    cer_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .geom      (geom),
        .cls_valid (fr_valid),
        .cls       (fr_cls)
    );

    cer_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .push_data (fr_cls),
        .pop_valid (q_valid),
        .pop_data  (q_cls),
        .full      (q_full)
    );

    cer_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .cls      (q_cls),
        .geom     (geom),
        .done     (done),
        .result   (result)
    );

    a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##22 fr_valid)
        else $error("front end lost a transaction");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##38 done)
        else $error("result missing after fixed latency");
    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.face <= cer_pkg::FACE_NZ)
        else $error("invalid face code");

endmodule
